// ===== src/utr_pkg.sv =====
// Package for the UTF-8 bitmap text renderer: constants, codes and payload types.
// No dependencies; every other file refers to it by scoped names.
package utr_pkg;
	localparam int MAX_GLYPHS = 512;
	localparam int MAX_HEIGHT = 32;
	localparam int MAP_DEPTH  = 64;
	localparam int GLYPH_AW   = 14;
	localparam int SLOT_W     = 6;

	localparam logic [1:0] OP_TEXT = 2'd0;
	localparam logic [1:0] OP_ROW  = 2'd1;
	localparam logic [1:0] OP_MAP  = 2'd2;

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_TOTAL   = 3'd2;
	localparam logic [2:0] REG_SPACING = 3'd3;
	localparam logic [2:0] REG_ORG_X   = 3'd4;
	localparam logic [2:0] REG_ORG_Y   = 3'd5;
	localparam logic [2:0] REG_ENTRIES = 3'd6;
	localparam logic [2:0] REG_COLOR   = 3'd7;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] row_mask;
		logic [23:0] pixel_color;
		logic        last_row;
	} out_t;
endpackage

// ===== src/utr_glyph_ram.sv =====
// Glyph bitmap memory: one 32-bit row per glyph line, one write and one read port.
// Uses utr_pkg for the address width.
module utr_glyph_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [utr_pkg::GLYPH_AW-1:0] waddr,
	input  logic [31:0]                  wdata,
	input  logic [utr_pkg::GLYPH_AW-1:0] raddr,
	output logic [31:0]                  rdata
);
	logic [31:0] mem [0:(1 << utr_pkg::GLYPH_AW)-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/utr_map_ram.sv =====
// Codepoint to glyph map memory: 21-bit code and 9-bit glyph per slot.
// Uses utr_pkg for the slot width.
module utr_map_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [utr_pkg::SLOT_W-1:0] waddr,
	input  logic [29:0]                wdata,
	input  logic [utr_pkg::SLOT_W-1:0] raddr,
	output logic [29:0]                rdata
);
	logic [29:0] mem [0:utr_pkg::MAP_DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/utf8_bitmap_text_renderer_core.sv =====
// Top level of the UTF-8 bitmap text renderer: decoder, map search and row sequencer.
// Depends on utr_pkg, utr_glyph_ram and utr_map_ram.
//
// Usage: words enter on the s_axis channel; s_axis_tuser selects the operation
// (0 UTF-8 text byte, 1 glyph row load, 2 map slot load). Each finished character
// that maps to a drawable glyph produces glyph_height_px words on m_axis, one per
// glyph line, with tlast set on the last one of the character.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data while idle.
// Loads, partial sequences and newlines are taken one per cycle, back to back.
// A printable ASCII character goes through the check state, the row sequencer, the read
// stage and the output register, then its rows come out one per cycle while the receiver
// takes them; the input is ready again once its last row has left the read stage. Any other
// codepoint first walks the map table one slot per cycle through the single map read port.
// A character that is not drawn passes the check state after any search and only moves the cursor.
// When the receiver stalls, the output register holds its word, one row waits in
// the read stage and the row sequencer stops; the input stays blocked until the
// last row of the character has left the read stage.
// Reset clears the cursor, decoder state and registers to their reset values;
// the memories are not cleared and read as undefined until written.
module utf8_bitmap_text_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tuser: operation[1:0]
	input  logic [1:0]  s_axis_tuser,
	// tdata: start_of_text[0], data_byte[8:1], glyph_sel[17:9], row_sel[22:18],
	// row_bits[54:23], map_slot[60:55], map_code[81:61], zeros
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: pos_x[15:0], pos_y[31:16], row_mask[63:32], pixel_color[87:64]
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_ROWS = 3'd3;

	logic [1:0]  in_op;
	logic        in_sot;
	logic [7:0]  in_byte;
	logic [8:0]  in_gsel;
	logic [4:0]  in_rsel;
	logic [31:0] in_bits;
	logic [5:0]  in_slot;
	logic [20:0] in_code;
	assign in_op   = s_axis_tuser;
	assign in_sot  = s_axis_tdata[0];
	assign in_byte = s_axis_tdata[8:1];
	assign in_gsel = s_axis_tdata[17:9];
	assign in_rsel = s_axis_tdata[22:18];
	assign in_bits = s_axis_tdata[54:23];
	assign in_slot = s_axis_tdata[60:55];
	assign in_code = s_axis_tdata[81:61];

	logic [5:0]  width_q, height_q;
	logic [9:0]  total_q;
	logic [7:0]  spacing_q;
	logic [15:0] org_x_q, org_y_q;
	logic [6:0]  entries_q;
	logic [23:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 6'd8; height_q <= 6'd16; total_q <= 10'd256; spacing_q <= 8'd1;
			org_x_q <= '0; org_y_q <= '0; entries_q <= '0; color_q <= 24'hFFFFFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				utr_pkg::REG_WIDTH:   width_q   <= cfg_data[5:0];
				utr_pkg::REG_HEIGHT:  height_q  <= cfg_data[5:0];
				utr_pkg::REG_TOTAL:   total_q   <= cfg_data[9:0];
				utr_pkg::REG_SPACING: spacing_q <= cfg_data[7:0];
				utr_pkg::REG_ORG_X:   org_x_q   <= cfg_data[15:0];
				utr_pkg::REG_ORG_Y:   org_y_q   <= cfg_data[15:0];
				utr_pkg::REG_ENTRIES: entries_q <= cfg_data[6:0];
				utr_pkg::REG_COLOR:   color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective width, height, glyph limit and map entry count after clamping, and the width mask.
	logic [5:0]  eff_w, eff_h;
	logic [9:0]  eff_total;
	logic [6:0]  eff_entries;
	logic [31:0] wmask;
	assign eff_w = (width_q > 6'd32) ? 6'd32 : width_q;
	assign eff_h = (height_q > 6'(utr_pkg::MAX_HEIGHT)) ? 6'(utr_pkg::MAX_HEIGHT) : height_q;
	assign eff_total = (total_q > 10'(utr_pkg::MAX_GLYPHS)) ? 10'(utr_pkg::MAX_GLYPHS) : total_q;
	assign eff_entries = (entries_q > 7'(utr_pkg::MAP_DEPTH)) ? 7'(utr_pkg::MAP_DEPTH) : entries_q;
	assign wmask = (eff_w == 6'd0) ? 32'd0 : ~(32'hFFFF_FFFF >> eff_w);

	logic [2:0]  state_q;
	logic [1:0]  pend_q;
	logic [20:0] acc_q;
	logic [15:0] cur_x_q, cur_y_q;
	logic [20:0] code_q;
	logic [6:0]  slot_q;
	logic [9:0]  glyph_q;
	logic [4:0]  row_q;
	logic        rd_v_s1;
	logic [4:0]  rd_row_s1;
	logic        rd_last_s1;
	logic [15:0] rd_x_s1;
	logic        ov_q;
	utr_pkg::out_t o_q;

	logic [31:0] g_rdata;
	logic [29:0] m_rdata;

	// Output register accepts a new word when empty or being drained.
	logic o_free;
	assign o_free = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !rd_v_s1;

	logic acc_in;
	assign acc_in = s_axis_tvalid && s_axis_tready;

	// Decoder combinational view with start_of_text applied first.
	logic [1:0]  d_pend;
	logic [20:0] d_acc;
	logic [15:0] d_x, d_y;
	logic [20:0] nx_acc;
	assign d_pend = in_sot ? 2'd0 : pend_q;
	assign d_acc  = in_sot ? 21'd0 : acc_q;
	assign d_x    = in_sot ? org_x_q : cur_x_q;
	assign d_y    = in_sot ? org_y_q : cur_y_q;
	assign nx_acc = {d_acc[14:0], in_byte[5:0]};

	// While a fetched row waits for the output register, its read is repeated so
	// that the memory output stays on that row.
	logic [4:0]  rd_row_sel;
	logic [13:0] g_raddr;
	assign rd_row_sel = (rd_v_s1 && !o_free) ? rd_row_s1 : row_q;
	assign g_raddr = {glyph_q[8:0], rd_row_sel};
	logic        row_go;
	assign row_go = (state_q == ST_ROWS) && (!rd_v_s1 || o_free);

	utr_glyph_ram u_glyph (
		.clk(clk),
		.we(acc_in && in_op == utr_pkg::OP_ROW),
		.waddr({in_gsel, in_rsel}), .wdata(in_bits),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	utr_map_ram u_map (
		.clk(clk),
		.we(acc_in && in_op == utr_pkg::OP_MAP),
		.waddr(in_slot), .wdata({in_gsel, in_code}),
		.raddr(slot_q[5:0]), .rdata(m_rdata)
	);

	// Next decoder state for the offered word, and whether it finishes a character.
	logic        start_ch;
	logic [20:0] start_cp;
	logic [1:0]  dec_pend;
	logic [20:0] dec_acc;
	logic [15:0] dec_x, dec_y;
	always_comb begin
		start_ch = 1'b0;
		start_cp = '0;
		dec_pend = d_pend;
		dec_acc  = d_acc;
		dec_x    = d_x;
		dec_y    = d_y;
		if (in_op == utr_pkg::OP_TEXT) begin
			if (d_pend != 2'd0) begin
				dec_pend = d_pend - 2'd1;
				dec_acc  = nx_acc;
				start_ch = (d_pend == 2'd1);
				start_cp = nx_acc;
			end else if (in_byte == 8'h0A) begin
				dec_x = org_x_q;
				dec_y = d_y + 16'(eff_h) + 16'(spacing_q);
			end else if (in_byte < 8'h80) begin
				start_ch = 1'b1;
				start_cp = {13'd0, in_byte};
			end else if ((in_byte & 8'hE0) == 8'hC0) begin
				dec_acc = {16'd0, in_byte[4:0]}; dec_pend = 2'd1;
			end else if ((in_byte & 8'hF0) == 8'hE0) begin
				dec_acc = {17'd0, in_byte[3:0]}; dec_pend = 2'd2;
			end else if ((in_byte & 8'hF8) == 8'hF0) begin
				dec_acc = {18'd0, in_byte[2:0]}; dec_pend = 2'd3;
			end else begin
				// A bad lead byte stands for codepoint zero.
				dec_acc  = '0;
				start_ch = 1'b1;
			end
		end
	end

	logic printable;
	assign printable = start_cp >= 21'd32 && start_cp <= 21'd126;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; pend_q <= '0; acc_q <= '0;
			cur_x_q <= '0; cur_y_q <= '0;
			slot_q <= '0; row_q <= '0; rd_v_s1 <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (o_free) ov_q <= rd_v_s1;
			if (row_go) rd_v_s1 <= 1'b1;
			else if (o_free) rd_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						pend_q <= dec_pend; acc_q <= dec_acc;
						cur_x_q <= dec_x; cur_y_q <= dec_y;
						if (start_ch) begin
							slot_q <= '0;
							if (printable) begin
								glyph_q <= 10'(start_cp);
								state_q <= ST_CHK;
							end else begin
								glyph_q <= 10'd32;
								state_q <= ST_SRCH;
							end
						end
					end
				end
				ST_SRCH: begin
					// slot_q addresses the read; data for slot_q-1 arrives now.
					if (slot_q != 7'd0 && m_rdata[20:0] == code_q) begin
						glyph_q <= {1'b0, m_rdata[29:21]};
						state_q <= ST_CHK;
					end else if (slot_q >= eff_entries) begin
						state_q <= ST_CHK;
					end else begin
						slot_q <= slot_q + 7'd1;
					end
				end
				ST_CHK: begin
					row_q <= '0;
					if (glyph_q < eff_total && eff_h != 6'd0) begin
						state_q <= ST_ROWS;
					end else begin
						cur_x_q <= cur_x_q + 16'(eff_w) + 16'(spacing_q);
						state_q <= ST_IDLE;
					end
				end
				ST_ROWS: begin
					if (row_go) begin
						row_q <= row_q + 5'd1;
						if (6'(row_q) + 6'd1 == eff_h) begin
							cur_x_q <= cur_x_q + 16'(eff_w) + 16'(spacing_q);
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && start_ch) code_q <= start_cp;
		if (row_go) begin
			rd_row_s1 <= row_q;
			rd_last_s1 <= (6'(row_q) + 6'd1 == eff_h);
			rd_x_s1 <= cur_x_q;
		end
		if (rd_v_s1 && o_free) begin
			o_q.pos_x <= rd_x_s1;
			o_q.pos_y <= cur_y_q + 16'(rd_row_s1);
			o_q.row_mask <= g_rdata & wmask;
			o_q.pixel_color <= color_q;
			o_q.last_row <= rd_last_s1;
		end
	end

	// The cursor advances when the last row is fetched, so each row carries the
	// column it was fetched at through the read stage.
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {o_q.pixel_color, o_q.row_mask, o_q.pos_y, o_q.pos_x};
	assign m_axis_tlast  = o_q.last_row;

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready)
		else $error("input taken during character");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROWS |-> 6'(row_q) < eff_h)
		else $error("row counter past glyph height");
`endif
endmodule

// ===== tb/utr_checker.sv =====
// Checker for the UTF-8 bitmap text renderer: watches the input, output and register
// channels, predicts every output word and compares. Depends on utr_pkg only.
`timescale 1ns / 100ps
module utr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,
	input  logic [87:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [87:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          rows_waiting
);
	logic [5:0]  width_px, height_px;
	logic [9:0]  total;
	logic [7:0]  spacing;
	logic [15:0] org_x, org_y;
	logic [6:0]  entries;
	logic [23:0] color;

	logic [1:0]  pending_bytes;
	logic [20:0] accum;
	logic [15:0] cur_x, cur_y;
	logic [31:0] glyph_rows [0:16383];
	logic [20:0] slot_code [0:63];
	logic [8:0]  slot_glyph [0:63];

	utr_pkg::out_t row_queue [$];

	assign rows_waiting = row_queue.size();

	task automatic render_char(input logic [20:0] cp);
		logic [9:0]  g;
		logic [6:0]  n;
		logic [5:0]  w, h;
		logic [9:0]  lim;
		logic [31:0] wmask;
		logic        found;
		utr_pkg::out_t o;
		g = (cp >= 21'd32 && cp <= 21'd126) ? cp[9:0] : 10'd32;
		if (!(cp >= 21'd32 && cp <= 21'd126)) begin
			n = (entries > 7'(utr_pkg::MAP_DEPTH)) ? 7'(utr_pkg::MAP_DEPTH) : entries;
			found = 1'b0;
			for (int i = 0; i < int'(n); i++) begin
				if (!found && slot_code[i] == cp) begin
					g = {1'b0, slot_glyph[i]};
					found = 1'b1;
				end
			end
		end
		w = (width_px > 6'd32) ? 6'd32 : width_px;
		h = (height_px > 6'(utr_pkg::MAX_HEIGHT)) ? 6'(utr_pkg::MAX_HEIGHT) : height_px;
		lim = (total > 10'(utr_pkg::MAX_GLYPHS)) ? 10'(utr_pkg::MAX_GLYPHS) : total;
		if (w == 6'd0)
			wmask = '0;
		else if (w >= 6'd32)
			wmask = '1;
		else
			wmask = 32'hFFFF_FFFF << (6'd32 - w);
		if (g < lim) begin
			for (int r = 0; r < int'(h); r++) begin
				o.pos_x = cur_x;
				o.pos_y = cur_y + 16'(r);
				o.row_mask = glyph_rows[{g[8:0], 5'(r)}] & wmask;
				o.pixel_color = color;
				o.last_row = (r + 1 == int'(h));
				row_queue.push_back(o);
			end
		end
		cur_x = cur_x + 16'(w) + 16'(spacing);
	endtask

	task automatic take_word(input logic [1:0] op, input logic [87:0] d);
		logic [7:0] b;
		logic [8:0] gsel;
		logic [4:0] rsel;
		logic [5:0] slot;
		logic [5:0] h;
		b = d[8:1];
		gsel = d[17:9];
		rsel = d[22:18];
		slot = d[60:55];
		if (d[0]) begin
			cur_x = org_x;
			cur_y = org_y;
			pending_bytes = 2'd0;
			accum = '0;
		end
		if (op == utr_pkg::OP_ROW) begin
			glyph_rows[{gsel, rsel}] = d[54:23];
		end else if (op == utr_pkg::OP_MAP) begin
			slot_code[slot] = d[81:61];
			slot_glyph[slot] = gsel;
		end else if (op == utr_pkg::OP_TEXT) begin
			if (pending_bytes != 2'd0) begin
				accum = {accum[14:0], b[5:0]};
				pending_bytes = pending_bytes - 2'd1;
				if (pending_bytes == 2'd0)
					render_char(accum);
			end else if (b == 8'h0A) begin
				h = (height_px > 6'(utr_pkg::MAX_HEIGHT)) ? 6'(utr_pkg::MAX_HEIGHT) : height_px;
				cur_x = org_x;
				cur_y = cur_y + 16'(h) + 16'(spacing);
			end else if (b < 8'h80) begin
				render_char({13'd0, b});
			end else if ((b & 8'hE0) == 8'hC0) begin
				accum = {16'd0, b[4:0]};
				pending_bytes = 2'd1;
			end else if ((b & 8'hF0) == 8'hE0) begin
				accum = {17'd0, b[3:0]};
				pending_bytes = 2'd2;
			end else if ((b & 8'hF8) == 8'hF0) begin
				accum = {18'd0, b[2:0]};
				pending_bytes = 2'd3;
			end else begin
				accum = '0;
				render_char(21'd0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		utr_pkg::out_t exp_row;
		logic [87:0] got;
		if (!arst_n) begin
			width_px = 6'd8; height_px = 6'd16; total = 10'd256; spacing = 8'd1;
			org_x = '0; org_y = '0; entries = '0; color = 24'hFFFFFF;
			pending_bytes = 2'd0; accum = '0; cur_x = '0; cur_y = '0;
			fail_count = 0;
			row_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					utr_pkg::REG_WIDTH:   width_px = cfg_data[5:0];
					utr_pkg::REG_HEIGHT:  height_px = cfg_data[5:0];
					utr_pkg::REG_TOTAL:   total = cfg_data[9:0];
					utr_pkg::REG_SPACING: spacing = cfg_data[7:0];
					utr_pkg::REG_ORG_X:   org_x = cfg_data[15:0];
					utr_pkg::REG_ORG_Y:   org_y = cfg_data[15:0];
					utr_pkg::REG_ENTRIES: entries = cfg_data[6:0];
					utr_pkg::REG_COLOR:   color = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (row_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word: data %h last %b", got, m_axis_tlast);
				end else begin
					exp_row = row_queue.pop_front();
					if (got[15:0] !== exp_row.pos_x || got[31:16] !== exp_row.pos_y ||
					    got[63:32] !== exp_row.row_mask ||
					    got[87:64] !== exp_row.pixel_color ||
					    m_axis_tlast !== exp_row.last_row) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: x %h/%h y %h/%h mask %h/%h color %h/%h last %b/%b",
								exp_row.pos_x, got[15:0], exp_row.pos_y, got[31:16],
								exp_row.row_mask, got[63:32], exp_row.pixel_color,
								got[87:64], exp_row.last_row, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_word(s_axis_tuser, s_axis_tdata);
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Top of the renderer testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on utr_pkg, the renderer core and utr_checker.
`timescale 1ns / 100ps
module testbench;
	// Operation code that the block ignores apart from start_of_text.
	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int LOADED_GLYPHS = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser = '0;
	logic [87:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [23:0] cfg_data = '0;
	int          fail_count;
	int          rows_waiting;

	// Long receiver hold-off requested by the stimulus, counted down by the receiver.
	int          hold_off = 0;
	int          burst_left = 0;
	// Codes written into the map slots, so that text can hit them on purpose.
	logic [20:0] slot_codes [0:63];

	always #6 clk = ~clk;

	utf8_bitmap_text_renderer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	utr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .rows_waiting(rows_waiting)
	);

	// Packs the data of one input word; the field order follows the tdata comment
	// of the core. The operation travels separately on tuser.
	function automatic logic [87:0] pack(input logic sot,
		input logic [7:0] b, input logic [8:0] gsel, input logic [4:0] rsel,
		input logic [31:0] bits, input logic [5:0] slot, input logic [20:0] code);
		return {6'd0, code, slot, bits, rsel, gsel, b, sot};
	endfunction

	// Only these glyphs get all their rows loaded, so the block never reads a glyph
	// row that was never written. Map targets and printable text come from this set.
	function automatic logic [8:0] glyph_of(input int i);
		case (i)
			0: return 9'd0;
			1: return 9'd32;
			2: return 9'd65;
			3: return 9'd126;
			4: return 9'd300;
			default: return 9'd511;
		endcase
	endfunction

	function automatic logic [8:0] loaded_glyph();
		return glyph_of($urandom_range(LOADED_GLYPHS - 1));
	endfunction

	function automatic logic [7:0] printable_byte();
		case ($urandom_range(2))
			0: return 8'h20;
			1: return 8'h41;
			default: return 8'h7E;
		endcase
	endfunction

	// Printable codepoints map to themselves, so only loaded ones may be used.
	function automatic logic [20:0] safe_cp(input logic [20:0] cp);
		if (cp >= 21'd32 && cp <= 21'd126 && cp != 21'd32 && cp != 21'd65 && cp != 21'd126)
			return 21'd65;
		return cp;
	endfunction

	function automatic logic [7:0] safe_byte(input logic [7:0] b);
		if (b >= 8'd32 && b <= 8'd126 && b != 8'd32 && b != 8'd65 && b != 8'd126)
			return 8'd65;
		return b;
	endfunction

	// The sender offers words in bursts; between bursts it may drop valid before going on.
	task automatic send(input logic [1:0] op, input logic [87:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic text(input logic [7:0] b, input logic sot = 1'b0);
		send(utr_pkg::OP_TEXT, pack(sot, b, 9'($urandom), 5'($urandom), $urandom,
			6'($urandom), 21'($urandom)));
	endtask

	// Waits until every predicted row has come out, then lets the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (rows_waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic setup(input logic [5:0] w, input logic [5:0] h, input logic [9:0] tot,
		input logic [7:0] sp, input logic [15:0] ox, input logic [15:0] oy,
		input logic [6:0] ent, input logic [23:0] col);
		drain();
		write_reg(utr_pkg::REG_WIDTH, 24'(w));
		write_reg(utr_pkg::REG_HEIGHT, 24'(h));
		write_reg(utr_pkg::REG_TOTAL, 24'(tot));
		write_reg(utr_pkg::REG_SPACING, 24'(sp));
		write_reg(utr_pkg::REG_ORG_X, 24'(ox));
		write_reg(utr_pkg::REG_ORG_Y, 24'(oy));
		write_reg(utr_pkg::REG_ENTRIES, 24'(ent));
		write_reg(utr_pkg::REG_COLOR, col);
	endtask

	// Sends a codepoint as a well-formed UTF-8 sequence of the shortest length.
	task automatic encode(input logic [20:0] cp, input logic sot);
		if (cp < 21'h80) begin
			text(cp[7:0], sot);
		end else if (cp < 21'h800) begin
			text({3'b110, cp[10:6]}, sot);
			text({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			text({4'b1110, cp[15:12]}, sot);
			text({2'b10, cp[11:6]});
			text({2'b10, cp[5:0]});
		end else begin
			text({5'b11110, cp[20:18]}, sot);
			text({2'b10, cp[17:12]});
			text({2'b10, cp[11:6]});
			text({2'b10, cp[5:0]});
		end
	endtask

	task automatic map_slot(input logic [5:0] slot, input logic [20:0] code,
		input logic [8:0] g);
		slot_codes[slot] = code;
		send(utr_pkg::OP_MAP, pack(1'b0, 8'($urandom), g, 5'($urandom), $urandom,
			slot, code));
	endtask

	// One random item: mostly well-formed text, some loads, noise and broken sequences.
	task automatic random_item();
		int k;
		logic sot;
		logic [20:0] cp;
		k = $urandom_range(99);
		sot = ($urandom_range(15) == 0);
		if (k < 40) begin
			text(printable_byte(), sot);
		end else if (k < 48) begin
			text(8'h0A, sot);
		end else if (k < 60) begin
			encode(slot_codes[$urandom_range(63)], sot);
		end else if (k < 70) begin
			case ($urandom_range(2))
				0: cp = 21'($urandom_range(21'h80, 21'h7FF));
				1: cp = 21'($urandom_range(21'h800, 21'hFFFF));
				default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
			endcase
			encode(cp, sot);
		end else if (k < 76) begin
			// Continuation bytes are taken raw, so any byte may follow a lead byte;
			// the lead leaves the codepoint above the printable range.
			text(8'hC2 + 8'($urandom_range(29)), sot);
			text(8'($urandom));
		end else if (k < 84) begin
			text(safe_byte(8'($urandom)), sot);
		end else if (k < 90) begin
			send(utr_pkg::OP_ROW, pack(sot, 8'($urandom),
				($urandom_range(3) == 0) ? 9'($urandom) : loaded_glyph(),
				5'($urandom), $urandom, 6'($urandom), 21'($urandom)));
		end else if (k < 96) begin
			cp = ($urandom_range(1) == 0) ? 21'($urandom) : 21'($urandom_range(255));
			cp = safe_cp(cp);
			slot_codes[$urandom_range(63)] = slot_codes[0];
			k = $urandom_range(63);
			slot_codes[k] = cp;
			send(utr_pkg::OP_MAP, pack(sot, 8'($urandom), loaded_glyph(), 5'($urandom),
				$urandom, 6'(k), cp));
		end else begin
			send(OP_IDLE, pack(sot, 8'($urandom), 9'($urandom), 5'($urandom), $urandom,
				6'($urandom), 21'($urandom)));
		end
	endtask

	// Receiver: changes its stall pattern now and then, and honors long hold-offs.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(3);
				left = $urandom_range(10, 200);
			end
			left--;
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(1) == 0);
					2: m_axis_tready <= ($urandom_range(4) == 0);
					default: m_axis_tready <= ($urandom_range(4) != 0);
				endcase
			end
		end
	end

	initial begin
		#(12 * 800000);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every row of the usable glyphs, including all-zero and all-one rows.
		for (int g = 0; g < LOADED_GLYPHS; g++) begin
			for (int r = 0; r < utr_pkg::MAX_HEIGHT; r++) begin
				send(utr_pkg::OP_ROW, pack(1'b0, 8'($urandom), glyph_of(g), 5'(r),
					(r == 0) ? 32'hFFFF_FFFF : (r == 1 ? 32'h0 : 32'($urandom)),
					6'($urandom), 21'($urandom)));
			end
		end
		// Fill every map slot. Two slots share a code so that the first match must win.
		map_slot(6'd0, 21'h0000E9, 9'd65);
		map_slot(6'd1, 21'h0020AC, 9'd300);
		map_slot(6'd2, 21'h01F600, 9'd511);
		map_slot(6'd3, 21'h000000, 9'd0);
		map_slot(6'd4, 21'h00007F, 9'd126);
		map_slot(6'd5, 21'h0000E9, 9'd32);
		map_slot(6'd6, 21'h1FFFFF, 9'd0);
		for (int s = 7; s < 64; s++)
			map_slot(6'(s), safe_cp(21'($urandom)), loaded_glyph());

		// Default settings, map search over the whole table.
		drain();
		write_reg(utr_pkg::REG_ENTRIES, 24'd64);

		// Directed text: printable edges, zero byte, DEL, each sequence length,
		// bad lead bytes, a newline inside a sequence, a start of text that cuts
		// a sequence, the unused operation and a start of text on a load.
		text("A", 1'b1);
		text(8'h20);
		text(8'h7E);
		text(8'h00);
		text(8'h7F);
		text(8'h0A);
		encode(21'h0000E9, 1'b0);
		encode(21'h0020AC, 1'b0);
		encode(21'h01F600, 1'b0);
		text(8'h80);
		text(8'hFF);
		text(8'hF8);
		text(8'hC3);
		text(8'h0A);
		text(8'hE2);
		text("~", 1'b1);
		send(OP_IDLE, pack(1'b1, 8'hFF, '1, '1, '1, '1, '1));
		send(utr_pkg::OP_ROW, pack(1'b1, 8'h41, 9'd511, 5'd31, 32'hA5A5_5A5A, '1, '1));
		encode(21'h1FFFFF, 1'b0);
		text(8'hF7);
		text(8'hBF);
		text(8'hBF);
		text(8'hBF);

		// Settings phases: defaults, upper extremes, lower extremes, zero width, values beyond
		// the limits, zero width and height, then random ones with small heights.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: setup(6'd8, 6'd16, 10'd256, 8'd1, 16'd0, 16'd0, 7'd64, 24'hFFFFFF);
				1: setup(6'd32, 6'd32, 10'd512, 8'd255, 16'hFFFF, 16'hFFFF, 7'd64,
					24'h000000);
				2: setup(6'd1, 6'd1, 10'd1, 8'd0, 16'd100, 16'd200, 7'd0, 24'h123456);
				3: setup(6'd0, 6'd5, 10'd300, 8'd7, 16'hFFF0, 16'hFFFA, 7'd10, 24'hABCDEF);
				4: setup(6'd63, 6'd63, 10'd1023, 8'd3, 16'd0, 16'h8000, 7'd127, 24'hFFFFFF);
				5: setup(6'd0, 6'd0, 10'd128, 8'd2, 16'd5, 16'd5, 7'd64, 24'h00FF00);
				default: setup(6'($urandom_range(1, 32)), 6'($urandom_range(1, 6)),
					10'($urandom_range(1, 512)), 8'($urandom), 16'($urandom),
					16'($urandom), 7'($urandom_range(64)), 24'($urandom));
			endcase
			text("A", 1'b1);
			for (int i = 0; i < 14; i++) begin
				// Hold the receiver off long enough that the block stalls its input.
				if (p == 1 && i == 5)
					hold_off = 400;
				// Let the sender pause until every row has come out.
				if (p == 2 && i == 7)
					drain();
				random_item();
			end
		end

		drain();
		if (fail_count == 0 && rows_waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/utr_pkg.sv
src/utr_glyph_ram.sv
src/utr_map_ram.sv
src/utf8_bitmap_text_renderer_core.sv
tb/utr_checker.sv
tb/testbench.sv
